### rtl/dcp_pkg.sv
// Shared types and constants of the critical-path priority engine.
package dcp_pkg;

  // Sizes of the node graph and of the priority range.
  localparam int NodeLimit     = 256;
  localparam int PriorityLimit = 1024;
  localparam int SrcPerNode    = 3;

  localparam int IdxW   = 8;
  localparam int AddrW  = $clog2(NodeLimit);
  localparam int NcW    = $clog2(NodeLimit + 1);
  localparam int PriW   = $clog2(PriorityLimit);
  localparam int KW     = $clog2(SrcPerNode + 1);
  localparam int CntW   = $clog2(SrcPerNode * NodeLimit + 1);
  localparam int TotW   = 18;
  localparam int LvlW   = 9;
  localparam int CostW  = 8;

  localparam logic [PriW-1:0] PriMax = PriW'(PriorityLimit - 1);

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  // Fault codes of a compute summary.
  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_CYCLE = 2'd1,
    FAULT_SAT   = 2'd2
  } fault_e;

  localparam logic KindSummary = 1'b0;
  localparam logic KindRead    = 1'b1;

  // Engine sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_LAT,
    ST_CNT_SRC,
    ST_CNT_WR,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP_RD,
    ST_POP_LAT,
    ST_SETTLE,
    ST_REL_SRC,
    ST_REL_WR,
    ST_SUM_RD,
    ST_SUM_LVL,
    ST_SUM_MARK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [IdxW-1:0] node_index;
    logic [7:0]      node_cost;
    logic            input_operand;
    logic            has_sources;
    logic [IdxW-1:0] source_a;
    logic [IdxW-1:0] source_b;
    logic [IdxW-1:0] source_c;
  } in_word_t;

  typedef struct packed {
    logic            result_kind;
    logic [9:0]      node_priority;
    logic [9:0]      max_input_priority;
    logic [17:0]     priority_total;
    logic [8:0]      level_count;
    logic [1:0]      fault;
  } out_word_t;

  // One stored node record.
  typedef struct packed {
    logic                             input_operand;
    logic                             has_sources;
    logic [SrcPerNode-1:0][IdxW-1:0]  src;
    logic [CostW-1:0]                 cost;
  } node_rec_t;

  // Per-node scheduling state: users not yet settled and best user priority.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [PriW-1:0] best;
  } user_rec_t;

endpackage

### rtl/dfg_critical_path_priority.sv
// Top level of the critical-path priority engine with its output register.
//
// A load word writes one node record. A read word reads the priority RAM and,
// in the read-out state, pushes the stored priority into the output register
// once the output slot is free; the next word is taken after that. A compute
// word first sweeps the 1024-entry level bitmap (the sweep also resets user
// counts and priorities of the loaded nodes). It then makes one pass over the
// nodes to count users, one to seed the ready queue, one settling pass through
// the queue and one summary pass. Every pass works by read-modify-writes on
// synchronous RAMs with registered read ports. Words are taken one at a time;
// a finished result waits in the output register while the next word runs.
module dfg_critical_path_priority (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dcp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dcp_pkg::out_word_t out_word_o
);

  logic               out_valid_q;
  dcp_pkg::out_word_t out_word_q;
  logic               res_free;
  logic               res_push;
  dcp_pkg::out_word_t res_word;

  // The slot is free when empty or being taken this cycle.
  assign res_free = !out_valid_q || !out_stall_i;

  dcp_engine u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_word_i,
    .in_stall_o,
    .res_free_i(res_free),
    .res_push_o(res_push),
    .res_word_o(res_word)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/dcp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dcp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dcp_engine.sv
// Sequencer and memories that load nodes, compute priorities and read them back.
module dcp_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dcp_pkg::in_word_t  in_word_i,
  output logic               in_stall_o,
  input  logic               res_free_i,
  output logic               res_push_o,
  output dcp_pkg::out_word_t res_word_o
);

  localparam int AddrW = dcp_pkg::AddrW;
  localparam int NcW   = dcp_pkg::NcW;
  localparam int PriW  = dcp_pkg::PriW;
  localparam int KW    = dcp_pkg::KW;

  dcp_pkg::state_e state_q, state_d;

  logic [NcW-1:0]  i_q, i_d;
  logic [PriW-1:0] clr_q, clr_d;
  logic [KW-1:0]   k_q, k_d;
  logic [NcW-1:0]  head_q, head_d, tail_q, tail_d, settled_q, settled_d;
  logic [NcW-1:0]  node_count_q, node_count_d;
  dcp_pkg::node_rec_t node_q, node_d;
  logic [AddrW-1:0] x_q, x_d;
  logic [PriW-1:0] p_q, p_d;
  logic            sat_q, sat_d;
  logic [PriW-1:0] maxin_q, maxin_d;
  logic [dcp_pkg::TotW-1:0] total_q, total_d;
  logic [dcp_pkg::LvlW-1:0] levels_q, levels_d;
  logic [dcp_pkg::NodeLimit-1:0] pri_vld_q;
  logic [AddrW-1:0] rd_addr_q;

  // Memory ports.
  logic nd_we, nd_re, us_we, us_re, qu_we, qu_re, pr_we, pr_re, bm_we, bm_re;
  logic [AddrW-1:0] nd_waddr, nd_raddr, us_waddr, us_raddr;
  logic [AddrW-1:0] qu_waddr, qu_raddr, pr_waddr, pr_raddr;
  logic [PriW-1:0]  bm_waddr, bm_raddr;
  dcp_pkg::node_rec_t nd_wdata, nd_rdata;
  dcp_pkg::user_rec_t us_wdata, us_rdata;
  logic [AddrW-1:0] qu_wdata, qu_rdata;
  logic [PriW-1:0]  pr_wdata, pr_rdata;
  logic             bm_wdata, bm_rdata;

  // Derived values.
  logic [dcp_pkg::IdxW-1:0] src_sel;
  logic            src_ok, k_last, i_end;
  logic [PriW:0]   p_sum;
  logic            p_sat;
  logic [PriW-1:0] p_new, rel_best, sum_p;
  logic [dcp_pkg::CntW-1:0] rel_cnt;
  logic            rel_push;
  logic            accept;
  dcp_pkg::node_rec_t load_rec;

  assign accept  = in_valid_i && (state_q == dcp_pkg::ST_IDLE);
  assign src_sel = node_q.src[k_q];
  assign src_ok  = node_q.has_sources && (NcW'(src_sel) < node_count_q);
  assign k_last  = (k_q == KW'(dcp_pkg::SrcPerNode - 1));
  assign i_end   = (i_q == node_count_q);

  // Settling a node: cost plus best user priority, held at the limit.
  assign p_sum = {1'b0, us_rdata.best} + (PriW + 1)'(nd_rdata.cost);
  assign p_sat = (p_sum > (PriW + 1)'(dcp_pkg::PriorityLimit - 1));
  assign p_new = p_sat ? dcp_pkg::PriMax : p_sum[PriW-1:0];

  // Releasing a source: raise its best user and drop its pending-user count.
  assign rel_best = (p_q > us_rdata.best) ? p_q : us_rdata.best;
  assign rel_cnt  = (us_rdata.cnt != '0) ? us_rdata.cnt - 1'b1 : '0;
  assign rel_push = (us_rdata.cnt == dcp_pkg::CntW'(1)) &&
                    (tail_q < NcW'(dcp_pkg::NodeLimit));

  // Priority readout; entries never written read as zero.
  assign sum_p = pri_vld_q[rd_addr_q] ? pr_rdata : '0;

  assign load_rec.input_operand = in_word_i.input_operand;
  assign load_rec.has_sources   = in_word_i.has_sources;
  assign load_rec.src           = {in_word_i.source_c, in_word_i.source_b,
                                   in_word_i.source_a};
  assign load_rec.cost          = in_word_i.node_cost;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.command == dcp_pkg::CMD_COMPUTE) begin
            state_d = dcp_pkg::ST_CLR;
          end else if (in_word_i.command == dcp_pkg::CMD_READ) begin
            state_d = dcp_pkg::ST_RD_OUT;
          end
        end
      end
      dcp_pkg::ST_RD_OUT:  if (res_free_i) state_d = dcp_pkg::ST_IDLE;
      dcp_pkg::ST_CLR:     if (clr_q == dcp_pkg::PriMax) state_d = dcp_pkg::ST_CNT_RD;
      dcp_pkg::ST_CNT_RD:  state_d = i_end ? dcp_pkg::ST_SEED_RD : dcp_pkg::ST_CNT_LAT;
      dcp_pkg::ST_CNT_LAT: state_d = dcp_pkg::ST_CNT_SRC;
      dcp_pkg::ST_CNT_SRC: begin
        if (src_ok) state_d = dcp_pkg::ST_CNT_WR;
        else if (k_last) state_d = dcp_pkg::ST_CNT_RD;
      end
      dcp_pkg::ST_CNT_WR:  state_d = k_last ? dcp_pkg::ST_CNT_RD : dcp_pkg::ST_CNT_SRC;
      dcp_pkg::ST_SEED_RD: state_d = i_end ? dcp_pkg::ST_POP_RD : dcp_pkg::ST_SEED_CHK;
      dcp_pkg::ST_SEED_CHK: state_d = dcp_pkg::ST_SEED_RD;
      dcp_pkg::ST_POP_RD: begin
        state_d = (head_q == tail_q) ? dcp_pkg::ST_SUM_RD : dcp_pkg::ST_POP_LAT;
      end
      dcp_pkg::ST_POP_LAT: state_d = dcp_pkg::ST_SETTLE;
      dcp_pkg::ST_SETTLE: begin
        state_d = nd_rdata.has_sources ? dcp_pkg::ST_REL_SRC : dcp_pkg::ST_POP_RD;
      end
      dcp_pkg::ST_REL_SRC: begin
        if (src_ok) state_d = dcp_pkg::ST_REL_WR;
        else if (k_last) state_d = dcp_pkg::ST_POP_RD;
      end
      dcp_pkg::ST_REL_WR:  state_d = k_last ? dcp_pkg::ST_POP_RD : dcp_pkg::ST_REL_SRC;
      dcp_pkg::ST_SUM_RD:  state_d = i_end ? dcp_pkg::ST_EMIT : dcp_pkg::ST_SUM_LVL;
      dcp_pkg::ST_SUM_LVL: state_d = dcp_pkg::ST_SUM_MARK;
      dcp_pkg::ST_SUM_MARK: state_d = dcp_pkg::ST_SUM_RD;
      dcp_pkg::ST_EMIT:    if (res_free_i) state_d = dcp_pkg::ST_IDLE;
      default:             state_d = dcp_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and result word.
  always_comb begin
    nd_we = 1'b0; nd_waddr = '0; nd_wdata = load_rec; nd_re = 1'b0; nd_raddr = '0;
    us_we = 1'b0; us_waddr = '0; us_wdata = '0;       us_re = 1'b0; us_raddr = '0;
    qu_we = 1'b0; qu_waddr = '0; qu_wdata = '0;       qu_re = 1'b0; qu_raddr = '0;
    pr_we = 1'b0; pr_waddr = '0; pr_wdata = '0;       pr_re = 1'b0; pr_raddr = '0;
    bm_we = 1'b0; bm_waddr = '0; bm_wdata = 1'b0;     bm_re = 1'b0; bm_raddr = '0;
    res_push_o = 1'b0;
    res_word_o = '0;
    unique case (state_q)
      dcp_pkg::ST_IDLE: begin
        if (in_valid_i && in_word_i.command == dcp_pkg::CMD_LOAD) begin
          nd_we    = 1'b1;
          nd_waddr = AddrW'(in_word_i.node_index);
        end
        if (in_valid_i && in_word_i.command == dcp_pkg::CMD_READ) begin
          pr_re    = 1'b1;
          pr_raddr = AddrW'(in_word_i.node_index);
        end
      end
      dcp_pkg::ST_RD_OUT: begin
        res_push_o               = res_free_i;
        res_word_o.result_kind   = dcp_pkg::KindRead;
        res_word_o.node_priority = 10'(sum_p);
      end
      dcp_pkg::ST_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        if (clr_q < PriW'(node_count_q)) begin
          us_we    = 1'b1;
          us_waddr = clr_q[AddrW-1:0];
          pr_we    = 1'b1;
          pr_waddr = clr_q[AddrW-1:0];
        end
      end
      dcp_pkg::ST_CNT_RD: begin
        nd_re    = !i_end;
        nd_raddr = i_q[AddrW-1:0];
      end
      dcp_pkg::ST_CNT_LAT: ;
      dcp_pkg::ST_CNT_SRC: begin
        us_re    = src_ok;
        us_raddr = AddrW'(src_sel);
      end
      dcp_pkg::ST_CNT_WR: begin
        us_we         = 1'b1;
        us_waddr      = AddrW'(src_sel);
        us_wdata.cnt  = us_rdata.cnt + 1'b1;
        us_wdata.best = us_rdata.best;
      end
      dcp_pkg::ST_SEED_RD: begin
        us_re    = !i_end;
        us_raddr = i_q[AddrW-1:0];
      end
      dcp_pkg::ST_SEED_CHK: begin
        qu_we    = (us_rdata.cnt == '0);
        qu_waddr = tail_q[AddrW-1:0];
        qu_wdata = i_q[AddrW-1:0];
      end
      dcp_pkg::ST_POP_RD: begin
        qu_re    = (head_q != tail_q);
        qu_raddr = head_q[AddrW-1:0];
      end
      dcp_pkg::ST_POP_LAT: begin
        nd_re    = 1'b1;
        nd_raddr = qu_rdata;
        us_re    = 1'b1;
        us_raddr = qu_rdata;
      end
      dcp_pkg::ST_SETTLE: begin
        pr_we    = 1'b1;
        pr_waddr = x_q;
        pr_wdata = p_new;
      end
      dcp_pkg::ST_REL_SRC: begin
        us_re    = src_ok;
        us_raddr = AddrW'(src_sel);
      end
      dcp_pkg::ST_REL_WR: begin
        us_we         = 1'b1;
        us_waddr      = AddrW'(src_sel);
        us_wdata.cnt  = rel_cnt;
        us_wdata.best = rel_best;
        qu_we         = rel_push;
        qu_waddr      = tail_q[AddrW-1:0];
        qu_wdata      = AddrW'(src_sel);
      end
      dcp_pkg::ST_SUM_RD: begin
        pr_re    = !i_end;
        pr_raddr = i_q[AddrW-1:0];
        nd_re    = !i_end;
        nd_raddr = i_q[AddrW-1:0];
      end
      dcp_pkg::ST_SUM_LVL: begin
        bm_re    = 1'b1;
        bm_raddr = sum_p;
      end
      dcp_pkg::ST_SUM_MARK: begin
        bm_we    = !bm_rdata;
        bm_waddr = p_q;
        bm_wdata = 1'b1;
      end
      dcp_pkg::ST_EMIT: begin
        res_push_o                    = res_free_i;
        res_word_o.result_kind        = dcp_pkg::KindSummary;
        res_word_o.max_input_priority = 10'(maxin_q);
        res_word_o.priority_total     = total_q;
        res_word_o.level_count        = levels_q;
        if (settled_q < node_count_q) begin
          res_word_o.fault = dcp_pkg::FAULT_CYCLE;
        end else if (sat_q) begin
          res_word_o.fault = dcp_pkg::FAULT_SAT;
        end else begin
          res_word_o.fault = dcp_pkg::FAULT_OK;
        end
      end
      default: ;
    endcase
  end

  // Counters and accumulators.
  always_comb begin
    i_d = i_q; clr_d = clr_q; k_d = k_q;
    head_d = head_q; tail_d = tail_q; settled_d = settled_q;
    node_count_d = node_count_q; node_d = node_q; x_d = x_q; p_d = p_q;
    sat_d = sat_q; maxin_d = maxin_q; total_d = total_q; levels_d = levels_q;
    unique case (state_q)
      dcp_pkg::ST_IDLE: begin
        if (accept && in_word_i.command == dcp_pkg::CMD_LOAD) begin
          if (NcW'(in_word_i.node_index) + NcW'(1) > node_count_q) begin
            node_count_d = NcW'(in_word_i.node_index) + NcW'(1);
          end
        end
        if (accept && in_word_i.command == dcp_pkg::CMD_COMPUTE) begin
          i_d = '0; clr_d = '0; k_d = '0;
          head_d = '0; tail_d = '0; settled_d = '0;
          sat_d = 1'b0; maxin_d = '0; total_d = '0; levels_d = '0;
        end
      end
      dcp_pkg::ST_CLR:     clr_d = clr_q + 1'b1;
      dcp_pkg::ST_CNT_RD:  if (i_end) i_d = '0;
      dcp_pkg::ST_CNT_LAT: node_d = nd_rdata;
      dcp_pkg::ST_CNT_SRC, dcp_pkg::ST_CNT_WR: begin
        if (state_q == dcp_pkg::ST_CNT_WR || !src_ok) begin
          if (k_last) begin
            k_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      dcp_pkg::ST_SEED_RD: if (i_end) i_d = '0;
      dcp_pkg::ST_SEED_CHK: begin
        if (us_rdata.cnt == '0) tail_d = tail_q + 1'b1;
        i_d = i_q + 1'b1;
      end
      dcp_pkg::ST_POP_RD:  if (head_q != tail_q) head_d = head_q + 1'b1;
      dcp_pkg::ST_POP_LAT: x_d = qu_rdata;
      dcp_pkg::ST_SETTLE: begin
        node_d    = nd_rdata;
        p_d       = p_new;
        settled_d = settled_q + 1'b1;
        sat_d     = sat_q | p_sat;
        k_d       = '0;
      end
      dcp_pkg::ST_REL_SRC, dcp_pkg::ST_REL_WR: begin
        if (state_q == dcp_pkg::ST_REL_WR && rel_push) tail_d = tail_q + 1'b1;
        if (state_q == dcp_pkg::ST_REL_WR || !src_ok) begin
          k_d = k_last ? '0 : k_q + 1'b1;
        end
      end
      dcp_pkg::ST_SUM_LVL: begin
        total_d = total_q + dcp_pkg::TotW'(sum_p);
        if (nd_rdata.input_operand && sum_p > maxin_q) maxin_d = sum_p;
        p_d = sum_p;
      end
      dcp_pkg::ST_SUM_MARK: begin
        if (!bm_rdata) levels_d = levels_q + 1'b1;
        i_d = i_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != dcp_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dcp_pkg::ST_IDLE;
      node_count_q <= '0;
      pri_vld_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      settled_q    <= '0;
      i_q          <= '0;
      clr_q        <= '0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      settled_q    <= settled_d;
      i_q          <= i_d;
      clr_q        <= clr_d;
      k_q          <= k_d;
      if (pr_we) pri_vld_q[pr_waddr] <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    x_q      <= x_d;
    p_q      <= p_d;
    sat_q    <= sat_d;
    maxin_q  <= maxin_d;
    total_q  <= total_d;
    levels_q <= levels_d;
    if (pr_re) rd_addr_q <= pr_raddr;
  end

  // Node records, user counts, ready queue, priorities and level bitmap.
  dcp_ram #(.Width($bits(dcp_pkg::node_rec_t)), .Depth(dcp_pkg::NodeLimit)) u_node_ram (
    .clk_i, .we_i(nd_we), .waddr_i(nd_waddr), .wdata_i(nd_wdata),
    .re_i(nd_re), .raddr_i(nd_raddr), .rdata_o(nd_rdata)
  );

  dcp_ram #(.Width($bits(dcp_pkg::user_rec_t)), .Depth(dcp_pkg::NodeLimit)) u_user_ram (
    .clk_i, .we_i(us_we), .waddr_i(us_waddr), .wdata_i(us_wdata),
    .re_i(us_re), .raddr_i(us_raddr), .rdata_o(us_rdata)
  );

  dcp_ram #(.Width(AddrW), .Depth(dcp_pkg::NodeLimit)) u_queue_ram (
    .clk_i, .we_i(qu_we), .waddr_i(qu_waddr), .wdata_i(qu_wdata),
    .re_i(qu_re), .raddr_i(qu_raddr), .rdata_o(qu_rdata)
  );

  dcp_ram #(.Width(PriW), .Depth(dcp_pkg::NodeLimit)) u_pri_ram (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(pr_wdata),
    .re_i(pr_re), .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );

  dcp_ram #(.Width(1), .Depth(dcp_pkg::PriorityLimit)) u_level_ram (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .re_i(bm_re), .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

`ifndef SYNTH
  // The ready queue is never read past its tail.
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("ready queue head passed tail");

  // No more nodes settle than the graph holds.
  a_settled_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q <= node_count_q) else $error("settled count exceeds node count");

  // A result word is only pushed into a free output slot.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_free_i) else $error("result pushed into full slot");

  // A compute always starts from an empty ready queue.
  a_clr_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcp_pkg::ST_CLR) |-> (tail_q == '0 && head_q == '0))
    else $error("ready queue not empty at compute start");
`endif

endmodule
